@@ rtl/dcrp_pkg.sv @@
// ----------------------------------------------------------------------------
// dcrp_pkg
// Shared types, constants and the write mask table of the register port.
// ----------------------------------------------------------------------------
package dcrp_pkg;

    localparam int unsigned QueueDepth = 2;

    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_LINE      = 4'd1,
        OP_TRI       = 4'd2,
        OP_TRI_FILL  = 4'd3,
        OP_ELL       = 4'd4,
        OP_ELL_FILL  = 4'd5,
        OP_RECT      = 4'd6,
        OP_RECT_FILL = 4'd7,
        OP_TEXT      = 4'd8
    } t_draw_op;

    // Kind of work the back end carries out for one word.
    typedef enum logic [2:0] {
        K_READ,
        K_PLAIN,
        K_SOFT_RST,
        K_STICKY,
        K_DRAW67,
        K_DRAW76,
        K_TEXT,
        K_NOP
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] addr;
        logic [7:0] data;
    } t_job;

    localparam logic [7:0] RegCtrl   = 8'h00;
    localparam logic [7:0] RegData   = 8'h04;
    localparam logic [7:0] RegSticky = 8'hE4;
    localparam logic [7:0] RegDraw67 = 8'h67;
    localparam logic [7:0] RegDraw76 = 8'h76;

    // Mask for a plain write; bit 8 set means the address is listed.
    function automatic logic [8:0] write_mask(input logic [7:0] a);
        logic [8:0] m;
        m = 9'h000;
        case (a) inside
            8'h01: m = 9'h17F;
            8'h02: m = 9'h1F6;
            8'h10: m = 9'h1DD;
            8'h05: m = 9'h1BF;
            8'h07, 8'h09, 8'h1B, 8'h5E: m = 9'h107;
            8'h06, 8'h08, 8'h0A, 8'h1F, 8'hD1: m = 9'h13F;
            8'h12: m = 9'h1EF;
            8'h15, 8'h17: m = 9'h10F;
            8'h1D: m = 9'h103;
            8'hCC: m = 9'h1F3;
            8'hCD: m = 9'h1DF;
            8'h16, 8'h18, 8'h19, 8'h25, 8'h27, 8'h29, 8'h57, 8'h59, 8'h55,
            8'h5B, 8'h5D, 8'h69, 8'h6B, 8'h6D, 8'h6F, 8'h71, 8'h73, 8'h64,
            8'h66, 8'h7C, 8'h7E, 8'h78, 8'h7A, 8'hD0: m = 9'h11F;
            8'h20, 8'h50, 8'h54: m = 9'h1FC;
            8'h03, 8'h13, 8'h14, 8'h1A, 8'h1C, 8'h1E, 8'h21, 8'h22, 8'h23,
            8'h51, 8'h52, 8'h53, 8'h24, 8'h26, 8'h28, 8'h56, 8'h58, 8'h5A,
            8'h5C, 8'hD2, 8'hD3, 8'hD4, 8'hD5, 8'hD6, 8'hD7, 8'h68, 8'h6A,
            8'h6C, 8'h6E, 8'h70, 8'h72, 8'h63, 8'h65, 8'h7B, 8'h7D, 8'h77,
            8'h79, 8'hE0, 8'hE1, 8'hE2, 8'hE3: m = 9'h1FF;
            default: m = 9'h000;
        endcase
        return m;
    endfunction

endpackage

@@ rtl/display_controller_register_port.sv @@
// ----------------------------------------------------------------------------
// display_controller_register_port
// Host register port of a display controller with draw command output.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready): one bus word per access, a read or a
// write of one byte to one of 256 registers.
// Output channel (o_valid/i_ready): exactly one result word per access,
// carrying the read byte or a draw command, unused fields zero.
// A front end classifies each word and puts it in a short queue; while the
// receiver takes results, the back end executes one job per cycle against
// the register file and registers the result. The queue entry and the result
// register lie between acceptance and o_valid; while not stalled, throughput
// is one word per cycle, set by the back end's single result register.
// When the receiver stalls the result holds, the queue fills and o_ready
// drops once it is full. Synchronous reset empties the queue, drops
// o_valid and loads the register file with its reset values.
// ----------------------------------------------------------------------------
module display_controller_register_port #(
    parameter int unsigned P_DEPTH = dcrp_pkg::QueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [7:0]  i_reg_addr,
    input  logic [7:0]  i_wdata,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_read_value,
    output logic [3:0]  o_draw_op,
    output logic [23:0] o_fg_colour,
    output logic [23:0] o_bg_colour,
    output logic [12:0] o_point_a_x,
    output logic [12:0] o_point_a_y,
    output logic [12:0] o_point_b_x,
    output logic [12:0] o_point_b_y,
    output logic [12:0] o_point_c_x,
    output logic [12:0] o_point_c_y,
    output logic [7:0]  o_glyph_code,
    output logic        o_transparent_bg
);
    import dcrp_pkg::*;

    t_job w_job;
    logic w_job_valid, w_job_ready;

    dcrp_front #(.P_DEPTH(P_DEPTH)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_command, .i_reg_addr, .i_wdata,
        .o_job_valid(w_job_valid), .i_job_ready(w_job_ready), .o_job(w_job)
    );

    dcrp_back u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(w_job_valid), .o_job_ready(w_job_ready), .i_job(w_job),
        .o_valid, .i_ready, .o_read_value, .o_draw_op, .o_fg_colour, .o_bg_colour,
        .o_point_a_x, .o_point_a_y, .o_point_b_x, .o_point_b_y,
        .o_point_c_x, .o_point_c_y, .o_glyph_code, .o_transparent_bg
    );
endmodule

@@ rtl/dcrp_front.sv @@
// ----------------------------------------------------------------------------
// dcrp_front
// Accepts bus words, classifies them and queues jobs for the back end.
// ----------------------------------------------------------------------------
module dcrp_front #(
    parameter int unsigned P_DEPTH = dcrp_pkg::QueueDepth
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic           i_command,
    input  logic [7:0]     i_reg_addr,
    input  logic [7:0]     i_wdata,
    output logic           o_job_valid,
    input  logic           i_job_ready,
    output dcrp_pkg::t_job o_job
);
    import dcrp_pkg::*;

    localparam int unsigned AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;

    t_job              r_mem [P_DEPTH];
    logic [AW-1:0]     r_wp, r_rp;
    logic [AW:0]       r_cnt;
    t_job              w_job;
    logic              w_push, w_pop;
    logic [8:0]        w_mask;

    assign w_mask = write_mask(i_reg_addr);

    always_comb begin
        w_job.addr = i_reg_addr;
        w_job.data = i_wdata;
        if (i_command) begin
            w_job.kind = K_READ;
        end else begin
            case (i_reg_addr)
                RegCtrl:   w_job.kind = i_wdata[0] ? K_SOFT_RST : K_NOP;
                RegSticky: w_job.kind = K_STICKY;
                RegDraw67: w_job.kind = K_DRAW67;
                RegDraw76: w_job.kind = K_DRAW76;
                RegData:   w_job.kind = K_TEXT;
                default:   w_job.kind = w_mask[8] ? K_PLAIN : K_NOP;
            endcase
        end
    end

    assign o_ready     = (r_cnt != P_DEPTH[AW:0]);
    assign w_push      = i_valid && o_ready;
    assign o_job_valid = (r_cnt != '0);
    assign w_pop       = o_job_valid && i_job_ready;
    assign o_job       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == AW'(P_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == AW'(P_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end
endmodule

@@ rtl/dcrp_back.sv @@
// ----------------------------------------------------------------------------
// dcrp_back
// Holds the register file and carries out queued jobs, one result each.
// ----------------------------------------------------------------------------
module dcrp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    output logic           o_job_ready,
    input  dcrp_pkg::t_job i_job,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_read_value,
    output logic [3:0]     o_draw_op,
    output logic [23:0]    o_fg_colour,
    output logic [23:0]    o_bg_colour,
    output logic [12:0]    o_point_a_x,
    output logic [12:0]    o_point_a_y,
    output logic [12:0]    o_point_b_x,
    output logic [12:0]    o_point_b_y,
    output logic [12:0]    o_point_c_x,
    output logic [12:0]    o_point_c_y,
    output logic [7:0]     o_glyph_code,
    output logic           o_transparent_bg
);
    import dcrp_pkg::*;

    // The register file is flip-flops: reset sets it at once, and the draw
    // fields read many fixed entries.
    logic [7:0]  r_rf [256];
    logic [7:0]  n_rf_val;
    logic [7:0]  n_rf_addr;
    logic        n_rf_we;
    logic        n_soft;
    logic        n_cur_we;
    logic [12:0] n_cur_x, n_cur_y;

    logic        r_valid;
    logic [7:0]  r_read_value, n_read_value;
    logic [3:0]  r_op, n_op;
    logic [23:0] r_fg, n_fg, r_bg, n_bg;
    logic [12:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic [12:0] n_ax, n_ay, n_bx, n_by, n_cx, n_cy;
    logic [7:0]  r_glyph, n_glyph;
    logic        r_tbg, n_tbg;

    logic [8:0]  w_mask;
    logic [4:0]  w_w;
    logic [5:0]  w_h;
    logic [14:0] w_nx, w_test, w_lim;
    logic [13:0] w_ny;
    logic [12:0] w_wx;

    function automatic logic [12:0] pt(input logic [7:0] lo, input logic [7:0] hi);
        return {hi[4:0], lo};
    endfunction

    assign o_job_ready = !r_valid || i_ready;
    assign w_mask = write_mask(i_job.addr);

    always_comb begin
        case (r_rf[8'hCC][5:4])
            2'd0:    begin w_w = 5'd8;  w_h = 6'd16; end
            2'd1:    begin w_w = 5'd12; w_h = 6'd24; end
            2'd2:    begin w_w = 5'd16; w_h = 6'd32; end
            default: begin w_w = 5'd0;  w_h = 6'd0;  end
        endcase
        w_wx   = pt(r_rf[8'h56], r_rf[8'h57]);
        w_nx   = 15'(pt(r_rf[8'h63], r_rf[8'h64])) + 15'(w_w) + 15'(r_rf[8'hD1][5:0]);
        w_test = w_nx + 15'(w_w);
        w_lim  = 15'(w_wx) + 15'(pt(r_rf[8'h5A], r_rf[8'h5B]));
        w_ny   = 14'(pt(r_rf[8'h65], r_rf[8'h66])) + 14'(w_h) + 14'(r_rf[8'hD0][4:0]);
    end

    always_comb begin
        n_rf_we = 1'b0; n_rf_addr = i_job.addr; n_rf_val = 8'h00;
        n_soft = 1'b0; n_cur_we = 1'b0;
        n_cur_x = w_nx[12:0]; n_cur_y = pt(r_rf[8'h65], r_rf[8'h66]);
        n_read_value = 8'h00; n_op = OP_NONE; n_fg = '0; n_bg = '0;
        n_ax = '0; n_ay = '0; n_bx = '0; n_by = '0; n_cx = '0; n_cy = '0;
        n_glyph = '0; n_tbg = 1'b0;
        case (i_job.kind)
            K_READ: begin
                n_read_value = (i_job.addr == RegData) ? 8'h00 : r_rf[i_job.addr];
            end
            K_PLAIN: begin
                n_rf_we = 1'b1; n_rf_val = i_job.data & w_mask[7:0];
            end
            K_SOFT_RST: n_soft = 1'b1;
            K_STICKY: begin
                n_rf_we = 1'b1; n_rf_val = i_job.data | {7'd0, r_rf[RegSticky][0]};
            end
            K_DRAW67: begin
                n_rf_we = 1'b1; n_rf_val = i_job.data & 8'h22;
                if (i_job.data[7]) begin
                    n_fg = {r_rf[8'hD2], r_rf[8'hD3], r_rf[8'hD4]};
                    n_ax = pt(r_rf[8'h68], r_rf[8'h69]); n_ay = pt(r_rf[8'h6A], r_rf[8'h6B]);
                    n_bx = pt(r_rf[8'h6C], r_rf[8'h6D]); n_by = pt(r_rf[8'h6E], r_rf[8'h6F]);
                    if (!i_job.data[1]) begin
                        n_op = OP_LINE;
                    end else begin
                        n_cx = pt(r_rf[8'h70], r_rf[8'h71]);
                        n_cy = pt(r_rf[8'h72], r_rf[8'h73]);
                        n_op = i_job.data[5] ? OP_TRI_FILL : OP_TRI;
                    end
                end
            end
            K_DRAW76: begin
                n_rf_we = 1'b1; n_rf_val = i_job.data & 8'h73;
                if (i_job.data[7] && i_job.data[4] == 1'b0) begin
                    n_fg = {r_rf[8'hD2], r_rf[8'hD3], r_rf[8'hD4]};
                    if (!i_job.data[5]) begin
                        n_ax = pt(r_rf[8'h7B], r_rf[8'h7C]); n_ay = pt(r_rf[8'h7D], r_rf[8'h7E]);
                        n_bx = pt(r_rf[8'h77], r_rf[8'h78]); n_by = pt(r_rf[8'h79], r_rf[8'h7A]);
                        n_op = i_job.data[6] ? OP_ELL_FILL : OP_ELL;
                    end else begin
                        n_ax = pt(r_rf[8'h68], r_rf[8'h69]); n_ay = pt(r_rf[8'h6A], r_rf[8'h6B]);
                        n_bx = pt(r_rf[8'h6C], r_rf[8'h6D]); n_by = pt(r_rf[8'h6E], r_rf[8'h6F]);
                        n_op = i_job.data[6] ? OP_RECT_FILL : OP_RECT;
                    end
                end
            end
            K_TEXT: begin
                if (r_rf[8'h03][2]) begin
                    n_op = OP_TEXT;
                    n_fg = {r_rf[8'hD2], r_rf[8'hD3], r_rf[8'hD4]};
                    n_bg = {r_rf[8'hD5], r_rf[8'hD6], r_rf[8'hD7]};
                    n_ax = pt(r_rf[8'h63], r_rf[8'h64]); n_ay = pt(r_rf[8'h65], r_rf[8'h66]);
                    n_glyph = i_job.data; n_tbg = r_rf[8'hCD][2];
                    n_cur_we = 1'b1;
                    // Wrap to the window's left edge and drop to the next text line.
                    if (w_test > w_lim) begin
                        n_cur_x = w_wx; n_cur_y = w_ny[12:0];
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 256; i++) begin
                r_rf[i] <= 8'h00;
            end
            r_rf[0] <= 8'hD6;
            r_rf[1] <= 8'h88;
        end else if (i_job_valid && o_job_ready) begin
            if (n_rf_we) begin
                r_rf[n_rf_addr] <= n_rf_val;
            end
            if (n_soft) begin
                r_rf[0] <= 8'hD6;
                r_rf[1] <= 8'h88;
            end
            if (n_cur_we) begin
                r_rf[8'h63] <= n_cur_x[7:0];
                r_rf[8'h64] <= {3'd0, n_cur_x[12:8]};
                r_rf[8'h65] <= n_cur_y[7:0];
                r_rf[8'h66] <= {3'd0, n_cur_y[12:8]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_job_ready) begin
            r_valid <= i_job_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job_valid && o_job_ready) begin
            r_read_value <= n_read_value; r_op <= n_op; r_fg <= n_fg; r_bg <= n_bg;
            r_ax <= n_ax; r_ay <= n_ay; r_bx <= n_bx; r_by <= n_by;
            r_cx <= n_cx; r_cy <= n_cy; r_glyph <= n_glyph; r_tbg <= n_tbg;
        end
    end

    assign o_valid = r_valid;
    assign o_read_value = r_read_value;
    assign o_draw_op = r_op;
    assign o_fg_colour = r_fg;
    assign o_bg_colour = r_bg;
    assign o_point_a_x = r_ax;
    assign o_point_a_y = r_ay;
    assign o_point_b_x = r_bx;
    assign o_point_b_y = r_by;
    assign o_point_c_x = r_cx;
    assign o_point_c_y = r_cy;
    assign o_glyph_code = r_glyph;
    assign o_transparent_bg = r_tbg;
endmodule

@@ rtl/dcrp_checker.sv @@
// ----------------------------------------------------------------------------
// dcrp_checker
// Port-level checks of the register port, bound to the top level.
// ----------------------------------------------------------------------------
module dcrp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_read_value,
    input logic [3:0]  o_draw_op,
    input logic [7:0]  o_glyph_code,
    input logic        o_transparent_bg
);
    import dcrp_pkg::*;

    // A read word never carries a draw and a draw never carries a read byte.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_read_value == 8'h00 || o_draw_op == OP_NONE))
        else $error("read value and draw op both set");

    a_glyph: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_draw_op != OP_TEXT) |-> (o_glyph_code == 8'h00 && !o_transparent_bg))
        else $error("text fields set on a non-text result");

    a_op_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_draw_op <= OP_TEXT))
        else $error("draw op out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_draw_op) && $stable(o_read_value)))
        else $error("stalled result changed");

    // A word taken with o_valid low yields a result via queue and result reg.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && !o_valid) |=> ##1 o_valid)
        else $error("result missing after accepted word");
endmodule

bind display_controller_register_port dcrp_checker u_dcrp_checker (
    .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
    .o_read_value, .o_draw_op, .o_glyph_code, .o_transparent_bg
);
